### hdl/dm64_pkg.sv
// Package for the pipelined 64-bit divider: shared widths and types.
// Used by every module under hdl; depends on nothing.
package dm64_pkg;

    localparam int FIELD_WIDTH = 64;   // width of each operand and result field
    localparam int DATA_WIDTH_DEF = 64;

    // Sign fix-up to apply once the magnitudes are divided
    typedef struct packed {
        logic neg_quot;
        logic neg_rem;
    } sign_t;

endpackage

### hdl/divide_modulo_64.sv
// Pipelined signed/unsigned divider, top level with output register and skid stage.
// Depends on dm64_pkg, dm64_prep, dm64_stage, dm64_fixup.
//
// Divides a dividend by a divisor and returns quotient (truncated toward zero) and
// remainder (sign of the dividend in signed mode). One item is accepted per cycle
// while s_tready is high. The pipeline has one input stage that takes magnitudes,
// DATA_WIDTH restoring subtract stages (one quotient bit each, the comparator of a
// stage sets the clock), one sign fix-up stage and the output register. Division by
// zero is not flagged: the quotient magnitude is all ones and the remainder
// magnitude equals the dividend magnitude, before the sign fix-up. With DATA_WIDTH
// below 64 only the low DATA_WIDTH bits of each operand are used and the upper
// result bits are zero. When the output is held, the skid stage takes one more
// item and then s_tready drops until the output moves again.
module divide_modulo_64
    import dm64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [2*FIELD_WIDTH-1:0] s_tdata,   // dividend [63:0], divisor [127:64]
    input  logic                     s_tuser,   // signed_mode [0]
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [2*FIELD_WIDTH-1:0] m_tdata    // quotient [63:0], remainder [127:64]
);

    localparam int W = DATA_WIDTH;

    logic         adv;
    logic         prep_valid;
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    sign_t        prep_sign;

    logic         vld_s  [0:W];
    logic [W-1:0] rem_s  [0:W];
    logic [W-1:0] nq_s   [0:W];
    logic [W-1:0] den_s  [0:W];
    sign_t        sign_s [0:W];

    logic         tail_valid;
    logic [W-1:0] tail_quot;
    logic [W-1:0] tail_rem;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic [W-1:0] out_quot_reg;
    logic [W-1:0] out_rem_reg;
    logic [W-1:0] skid_quot_reg;
    logic [W-1:0] skid_rem_reg;
    logic         out_free;
    logic         load_out_tail;
    logic         load_out_skid;
    logic         load_skid;
    logic [FIELD_WIDTH-1:0] quot_ext;
    logic [FIELD_WIDTH-1:0] rem_ext;

    // whole pipeline moves together; it holds only while the skid stage is occupied
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    dm64_prep #(.W(W)) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_tvalid),
        .dividend    (s_tdata[W-1:0]),
        .divisor     (s_tdata[FIELD_WIDTH+W-1:FIELD_WIDTH]),
        .signed_mode (s_tuser),
        .out_valid   (prep_valid),
        .num_mag     (num_mag),
        .den_mag     (den_mag),
        .sign        (prep_sign)
    );

    assign vld_s[0]  = prep_valid;
    assign rem_s[0]  = '0;
    assign nq_s[0]   = num_mag;
    assign den_s[0]  = den_mag;
    assign sign_s[0] = prep_sign;

    for (genvar k = 0; k < W; k++)
    begin : g_step
        dm64_stage #(.W(W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (vld_s[k]),
            .rem_in    (rem_s[k]),
            .nq_in     (nq_s[k]),
            .den_in    (den_s[k]),
            .sign_in   (sign_s[k]),
            .out_valid (vld_s[k+1]),
            .rem_out   (rem_s[k+1]),
            .nq_out    (nq_s[k+1]),
            .den_out   (den_s[k+1]),
            .sign_out  (sign_s[k+1])
        );
    end

    dm64_fixup #(.W(W)) u_fixup (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vld_s[W]),
        .quot_mag  (nq_s[W]),
        .rem_mag   (rem_s[W]),
        .sign      (sign_s[W]),
        .out_valid (tail_valid),
        .quotient  (tail_quot),
        .remainder (tail_rem)
    );

    // output register with one skid entry behind it
    always_comb
    begin
        out_free        = !out_valid_reg || m_tready;
        load_out_skid   = out_free && skid_valid_reg;
        load_out_tail   = out_free && !skid_valid_reg && tail_valid;
        load_skid       = !out_free && adv && tail_valid;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || tail_valid;
            skid_valid_next = 1'b0;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            out_quot_reg <= skid_quot_reg;
            out_rem_reg  <= skid_rem_reg;
        end
        else if (load_out_tail)
        begin
            out_quot_reg <= tail_quot;
            out_rem_reg  <= tail_rem;
        end
        if (load_skid)
        begin
            skid_quot_reg <= tail_quot;
            skid_rem_reg  <= tail_rem;
        end
    end

    always_comb
    begin
        quot_ext = '0;
        rem_ext  = '0;
        quot_ext[W-1:0] = out_quot_reg;
        rem_ext[W-1:0]  = out_rem_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {rem_ext, quot_ext};

    // the skid entry is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // a finished item arriving at a held output must land in the skid entry
    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && tail_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("finished item lost at held output");

    // once the output is taken, the skid entry moves to the output register in the next cycle
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry did not move to output");

endmodule

### hdl/dm64_prep.sv
// Input stage of the divider: register operands, take magnitudes in signed mode.
// Depends on dm64_pkg.
module dm64_prep
    import dm64_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_valid,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    input  logic         signed_mode,
    output logic         out_valid,
    output logic [W-1:0] num_mag,
    output logic [W-1:0] den_mag,
    output sign_t        sign
);

    logic         valid_reg;
    logic [W-1:0] num_reg;
    logic [W-1:0] num_next;
    logic [W-1:0] den_reg;
    logic [W-1:0] den_next;
    sign_t        sign_reg;
    sign_t        sign_next;
    logic         neg_a;
    logic         neg_b;

    always_comb
    begin
        neg_a = signed_mode & dividend[W-1];
        neg_b = signed_mode & divisor[W-1];
        num_next = neg_a ? (~dividend + 1'b1) : dividend;
        den_next = neg_b ? (~divisor + 1'b1) : divisor;
        sign_next.neg_quot = neg_a ^ neg_b;
        sign_next.neg_rem  = neg_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            sign_reg <= sign_next;
        end
    end

    assign out_valid = valid_reg;
    assign num_mag   = num_reg;
    assign den_mag   = den_reg;
    assign sign      = sign_reg;

endmodule

### hdl/dm64_stage.sv
// One restoring shift-subtract step of the divider, one quotient bit per stage.
// Depends on dm64_pkg.
module dm64_stage
    import dm64_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_valid,
    input  logic [W-1:0] rem_in,
    input  logic [W-1:0] nq_in,     // unused numerator bits above, quotient bits below
    input  logic [W-1:0] den_in,
    input  sign_t        sign_in,
    output logic         out_valid,
    output logic [W-1:0] rem_out,
    output logic [W-1:0] nq_out,
    output logic [W-1:0] den_out,
    output sign_t        sign_out
);

    logic         valid_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] nq_reg;
    logic [W-1:0] nq_next;
    logic [W-1:0] den_reg;
    sign_t        sign_reg;
    logic [W:0]   shifted;
    logic [W:0]   diff;
    logic         fits;

    always_comb
    begin
        // bring down the next numerator bit, subtract if the divisor fits
        shifted = {rem_in, nq_in[W-1]};
        diff    = shifted - {1'b0, den_in};
        fits    = (shifted >= {1'b0, den_in});
        rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
        nq_next  = {nq_in[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            den_reg  <= den_in;
            sign_reg <= sign_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign nq_out    = nq_reg;
    assign den_out   = den_reg;
    assign sign_out  = sign_reg;

endmodule

### hdl/dm64_fixup.sv
// Final stage of the divider: apply the sign fix-up to quotient and remainder.
// Depends on dm64_pkg.
module dm64_fixup
    import dm64_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         adv,
    input  logic         in_valid,
    input  logic [W-1:0] quot_mag,
    input  logic [W-1:0] rem_mag,
    input  sign_t        sign,
    output logic         out_valid,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    logic         valid_reg;
    logic [W-1:0] quot_reg;
    logic [W-1:0] quot_next;
    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;

    always_comb
    begin
        quot_next = sign.neg_quot ? (~quot_mag + 1'b1) : quot_mag;
        rem_next  = sign.neg_rem  ? (~rem_mag + 1'b1)  : rem_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
